// ===== rtl/core/psmpd_pkg.sv =====
// Shared types and constants for the point set diameter core.
// Used by every module under rtl/core except psmpd_point_mem; no dependencies of its own.
`timescale 1ns / 1ps

package psmpd_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned DSQ_W  = 50;
  localparam int unsigned DIST_W = 25;

  // Coordinates are sign-extended to this width before subtraction
  // (holds any coordinate width up to 32 bits).
  localparam int unsigned EXT_W  = 33;

  // Magnitudes of 2^MAG_W or more square beyond the result range
  localparam int unsigned MAG_W  = 25;

  localparam logic [DSQ_W-1:0] SQ_MAX = {DSQ_W{1'b1}};

  // Defaults for the top-level parameters
  localparam int unsigned MAX_POINTS_DEF  = 1024;
  localparam int unsigned COORD_WIDTH_DEF = 24;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_EMIT
  } state_e;

  // Status from the distance pipeline to the sequencer
  typedef struct packed {
    logic             busy;     // any stage holds a beat
    logic             vld;      // dist_sq is a fresh result
    logic [DSQ_W-1:0] dist_sq;  // saturated squared distance
  } pipe_st_t;

endpackage

// ===== rtl/core/psmpd_point_mem.sv =====
// Point store: one write port, one synchronous (registered) read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module psmpd_point_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 72
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/psmpd_dist_pipe.sv =====
// Three-stage squared distance pipeline: difference, square, saturating sum.
// Depends on psmpd_pkg; fed from psmpd_point_mem read data.
`timescale 1ns / 1ps

module psmpd_dist_pipe #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_issue_i,  // a store read is issued
  input  logic [3*COORD_WIDTH-1:0]   rd_data_i,   // {z, y, x}
  input  logic [3*COORD_WIDTH-1:0]   pt_i,        // {z, y, x} of the new point
  output psmpd_pkg::pipe_st_t        status_o
);
  import psmpd_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;

  logic                 rd_vld_q;
  logic                 mag_vld_q;
  logic                 sq_vld_q;
  logic                 sum_vld_q;

  logic [2:0]           big_d, big_q;
  logic [MAG_W-1:0]     mag_d [3];
  logic [MAG_W-1:0]     mag_q [3];
  logic [DSQ_W-1:0]     sq_q  [3];
  logic                 sq_big_q;
  logic [DSQ_W+1:0]     sum;
  logic [DSQ_W-1:0]     dist_q;

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mag_vld_q <= 1'b0;
      sq_vld_q  <= 1'b0;
      sum_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= rd_issue_i;
      mag_vld_q <= rd_vld_q;
      sq_vld_q  <= mag_vld_q;
      sum_vld_q <= sq_vld_q;
    end
  end

  // Stage 1: per-axis absolute difference, flag magnitudes out of range
  always_comb begin
    logic [EXT_W-1:0] ea;
    logic [EXT_W-1:0] eb;
    logic [EXT_W:0]   d;
    logic [EXT_W:0]   ad;
    for (int k = 0; k < 3; k++) begin
      ea = {{(EXT_W-CW){pt_i[k*CW+CW-1]}}, pt_i[k*CW +: CW]};
      eb = {{(EXT_W-CW){rd_data_i[k*CW+CW-1]}}, rd_data_i[k*CW +: CW]};
      d  = {ea[EXT_W-1], ea} - {eb[EXT_W-1], eb};
      ad = d[EXT_W] ? (~d + 1'b1) : d;
      big_d[k] = |ad[EXT_W:MAG_W];
      mag_d[k] = ad[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      big_q <= big_d;
      for (int k = 0; k < 3; k++) begin
        mag_q[k] <= mag_d[k];
      end
    end
  end

  // Stage 2: squares, one 25x25 multiplier per axis
  always_ff @(posedge clk_i) begin
    if (mag_vld_q) begin
      sq_big_q <= |big_q;
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= DSQ_W'(mag_q[k] * mag_q[k]);
      end
    end
  end

  // Stage 3: sum and saturate
  assign sum = (DSQ_W+2)'(sq_q[0]) + (DSQ_W+2)'(sq_q[1]) + (DSQ_W+2)'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (sq_vld_q) begin
      if (sq_big_q || (sum > (DSQ_W+2)'(SQ_MAX))) begin
        dist_q <= SQ_MAX;
      end else begin
        dist_q <= sum[DSQ_W-1:0];
      end
    end
  end

  assign status_o.busy    = rd_vld_q | mag_vld_q | sq_vld_q | sum_vld_q;
  assign status_o.vld     = sum_vld_q;
  assign status_o.dist_sq = dist_q;

endmodule

// ===== rtl/core/psmpd_isqrt.sv =====
// Bit-serial floor square root of a 50-bit value, one result bit per cycle.
// Depends on psmpd_pkg.
`timescale 1ns / 1ps

module psmpd_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [psmpd_pkg::DSQ_W-1:0]   value_i,
  output logic                          done_o,
  output logic [psmpd_pkg::DIST_W-1:0]  root_o
);
  import psmpd_pkg::*;

  localparam int unsigned REM_W  = DIST_W + 2;
  localparam int unsigned STEP_W = $clog2(DIST_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIST_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DSQ_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [DIST_W-1:0] root_q;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  // One restoring step: bring down two radicand bits, try root*4+1
  assign rem_sh = {rem_q, rad_q[DSQ_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[DSQ_W-3:0], 2'b00};
      rem_q  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_q <= {root_q[DIST_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/point_set_max_pairwise_distance_core.sv =====
// Point set diameter core: the largest squared distance over the points of a cell.
// Per point: the sequencer reads each of the n stored points, one store read per cycle,
// then waits for the distance pipeline to drain; n = points already stored (at most MAX_POINTS).
// A last point then computes the square root and loads the result into the output register.
// One point at a time; one waiting result does not block input, a second result waits for it.
// Reset clears the count, running maximum, overflow flag and handshakes at once; the point
// store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module point_set_max_pairwise_distance_core #(
  parameter int unsigned MAX_POINTS  = psmpd_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_WIDTH = psmpd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // Input beats: one point
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // pos_x, pos_y, pos_z (COORD_WIDTH each), cell_tag (16), zero pad
  input  logic [((3*COORD_WIDTH+psmpd_pkg::TAG_W+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                        s_axis_tlast,   // last_point
  // Output beats: one cell result
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // result_tag (16), max_dist_sq (50), max_dist (25), zero pad
  output logic [95:0]                                 m_axis_tdata,
  output logic                                        m_axis_tuser    // point_overflow
);
  import psmpd_pkg::*;

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned PT_W  = 3 * CW;
  localparam int unsigned AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
  localparam int unsigned OUT_W = TAG_W + DSQ_W + DIST_W;

  state_e            state_q, state_d;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  scan_n_q, scan_n_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              ovf_q, ovf_d;
  logic              ovf_res_q, ovf_res_d;
  logic              last_q, last_d;
  logic [DSQ_W-1:0]  best_q, best_d;
  logic [DSQ_W-1:0]  dsq_res_q, dsq_res_d;

  logic [PT_W-1:0]   pt_q;
  logic [TAG_W-1:0]  tag_q;

  logic              out_vld_q, out_vld_d;
  logic [OUT_W-1:0]  out_data_q;
  logic              out_ovf_q;
  logic              out_load;

  logic              in_acc;
  logic              store_full;
  logic              rd_issue;
  logic              root_start;
  logic              root_done;
  logic [DIST_W-1:0] root;
  logic [PT_W-1:0]   rd_data;
  pipe_st_t          pipe_st;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign store_full = (count_q >= CNT_MAX);

  // Point store, written at the fill position when a point is taken and the store is not full
  psmpd_point_mem #(
    .DEPTH  (MAX_POINTS),
    .DATA_W (PT_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && !store_full),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (s_axis_tdata[PT_W-1:0]),
    .rd_en_i   (rd_issue),
    .rd_addr_i (idx_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  psmpd_dist_pipe #(
    .COORD_WIDTH (CW)
  ) u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_issue_i (rd_issue),
    .rd_data_i  (rd_data),
    .pt_i       (pt_q),
    .status_o   (pipe_st)
  );

  psmpd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (best_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  // Sequencer: next state and control
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_n_d   = scan_n_q;
    idx_d      = idx_q;
    ovf_d      = ovf_q;
    ovf_res_d  = ovf_res_q;
    last_d     = last_q;
    best_d     = best_q;
    dsq_res_d  = dsq_res_q;
    rd_issue   = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    s_axis_tready = 1'b0;

    // Running maximum
    if (pipe_st.vld && (pipe_st.dist_sq > best_q)) begin
      best_d = pipe_st.dist_sq;
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          scan_n_d  = count_q;
          idx_d     = '0;
          last_d    = s_axis_tlast;
          ovf_res_d = ovf_q | store_full;
          if (s_axis_tlast) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end else if (store_full) begin
            ovf_d   = 1'b1;
          end else begin
            count_d = count_q + 1'b1;
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q == scan_n_q) begin
          state_d = ST_DRAIN;
        end else begin
          rd_issue = 1'b1;
          idx_d    = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!pipe_st.busy) begin
          if (last_q) begin
            root_start = 1'b1;
            dsq_res_d  = best_q;
            best_d     = '0;
            state_d    = ST_ROOT;
          end else begin
            state_d    = ST_IDLE;
          end
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      scan_n_q  <= '0;
      idx_q     <= '0;
      ovf_q     <= 1'b0;
      ovf_res_q <= 1'b0;
      last_q    <= 1'b0;
      best_q    <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      scan_n_q  <= scan_n_d;
      idx_q     <= idx_d;
      ovf_q     <= ovf_d;
      ovf_res_q <= ovf_res_d;
      last_q    <= last_d;
      best_q    <= best_d;
    end
  end

  // Captured beat and held result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pt_q  <= s_axis_tdata[PT_W-1:0];
      tag_q <= s_axis_tdata[PT_W +: TAG_W];
    end
    dsq_res_q <= dsq_res_d;
  end

  // Output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {root, dsq_res_q, tag_q};
      out_ovf_q  <= ovf_res_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(96-OUT_W)'(0), out_data_q};
  assign m_axis_tuser  = out_ovf_q;

  // Checks
  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_st.vld |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("distance result outside a scan");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("point count beyond store depth");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (count_q == '0 && !ovf_q))
    else $error("cell state not cleared after last point");

  a_root_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (state_q == ST_ROOT))
    else $error("root finished outside its state");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_issue |-> (idx_q < scan_n_q))
    else $error("read beyond stored points");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for point_set_max_pairwise_distance_core (default parameters).
// Predicts each cell's diameter from the accepted point beats and checks every result beat.
// Depends on psmpd_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
  import psmpd_pkg::*;

  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned IN_W       = ((3*COORD_W+TAG_W+7)/8)*8;
  localparam int unsigned RAND_ITEMS = 560;
  localparam int unsigned HOLD_AFTER = 60;      // points accepted before the long hold-off
  localparam int unsigned HOLD_LEN   = 3000;
  localparam int unsigned DRAIN_WAIT = 1200;    // a full store scan plus the root
  localparam int unsigned CYCLE_CAP  = 3000000;
  localparam int unsigned PRINT_CAP  = 40;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = coord_t'(2**(COORD_W-1) - 1);
  localparam coord_t COORD_MIN = coord_t'(-(2**(COORD_W-1)));

  typedef struct {
    coord_t             x, y, z;
    logic [TAG_W-1:0]   tag;
    logic               last;
  } point_t;

  typedef struct {
    logic [TAG_W-1:0]   tag;
    logic [DSQ_W-1:0]   dsq;
    logic [DIST_W-1:0]  root_len;
    logic               spill;
  } cell_result_t;

  // How the coordinates of one random cell are spread
  typedef enum int { SP_WIDE, SP_TIGHT, SP_NEAR, SP_EDGE } spread_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;       // pos_x, pos_y, pos_z, cell_tag
  logic              s_axis_tlast = 1'b0;     // last_point
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [95:0]       m_axis_tdata;            // result_tag, max_dist_sq, max_dist, pad
  logic              m_axis_tuser;            // point_overflow

  point_t            point_q[$];
  cell_result_t      diameter_q[$];

  // Predictor state: points held for the open cell
  coord_t            held_x[CAPACITY];
  coord_t            held_y[CAPACITY];
  coord_t            held_z[CAPACITY];
  int unsigned       held_count = 0;
  logic [DSQ_W-1:0]  running_max = '0;
  bit                spill_seen = 1'b0;

  int unsigned       points_total = 0;
  int unsigned       points_accepted = 0;
  int unsigned       results_checked = 0;
  int unsigned       spill_results = 0;
  int unsigned       err_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       stall_run = 0;
  int unsigned       stall_longest = 0;

  bit                in_beat_done = 1'b0;
  int unsigned       burst_left = 0;
  int unsigned       idle_left = 0;
  point_t            next_pt;
  int unsigned       hold_left = 0;
  bit                hold_done = 1'b0;
  int unsigned       rx_mode = 0;
  int unsigned       rx_mode_left = 0;

  point_set_max_pairwise_distance_core #(
    .MAX_POINTS  (CAPACITY),
    .COORD_WIDTH (COORD_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Exact squared distance, saturated to the result width
  function automatic logic [DSQ_W-1:0] span_sq(input coord_t ax, ay, az, bx, by, bz);
    longint dx, dy, dz;
    longint unsigned total;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    dz = longint'(az) - longint'(bz);
    total = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    if (total > longint'(SQ_MAX)) total = SQ_MAX;
    return total[DSQ_W-1:0];
  endfunction

  // Floor square root, built one result bit at a time from the top
  function automatic logic [DIST_W-1:0] root_floor(input logic [DSQ_W-1:0] v);
    longint unsigned r, trial;
    r = 0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r[DIST_W-1:0];
  endfunction

  // Fold one accepted point into the open cell; close the cell on its last point
  task automatic fold_point(input point_t p);
    logic [DSQ_W-1:0] d;
    cell_result_t     res;
    for (int i = 0; i < held_count; i++) begin
      d = span_sq(p.x, p.y, p.z, held_x[i], held_y[i], held_z[i]);
      if (d > running_max) running_max = d;
    end
    if (held_count < CAPACITY) begin
      held_x[held_count] = p.x;
      held_y[held_count] = p.y;
      held_z[held_count] = p.z;
      held_count++;
    end else begin
      spill_seen = 1'b1;
    end
    if (p.last) begin
      res.tag      = p.tag;
      res.dsq      = running_max;
      res.root_len = root_floor(running_max);
      res.spill    = spill_seen;
      diameter_q   = {diameter_q, res};
      held_count  = 0;
      running_max = '0;
      spill_seen  = 1'b0;
    end
  endtask

  task automatic queue_point(input coord_t x, y, z, input logic [TAG_W-1:0] tag,
                             input logic last);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.tag = tag;
    p.last = last;
    point_q = {point_q, p};
    points_total++;
  endtask

  function automatic coord_t pick_coord(input spread_e s, input coord_t centre);
    case (s)
      SP_WIDE:  return coord_t'($urandom());
      SP_TIGHT: return coord_t'(int'($urandom_range(0, 64)) - 32);
      SP_NEAR:  return coord_t'(int'(centre) + int'($urandom_range(0, 2000)) - 1000);
      default:  return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    endcase
  endfunction

  // One random cell; the tag sometimes changes part way through
  task automatic queue_cell(input int unsigned n);
    spread_e          s;
    coord_t           cx, cy, cz;
    logic [TAG_W-1:0] tag;
    s = spread_e'($urandom_range(0, 3));
    cx = coord_t'($urandom());
    cy = coord_t'($urandom());
    cz = coord_t'($urandom());
    tag = TAG_W'($urandom());
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 15) tag = TAG_W'($urandom());
      queue_point(pick_coord(s, cx), pick_coord(s, cy), pick_coord(s, cz), tag, k == n - 1);
    end
  endtask

  // Sender: bursts of point beats with random gaps, held until accepted
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_beat_done)) begin
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (point_q.size() != 0) begin
        next_pt = point_q.pop_front();
        s_axis_tdata <= IN_W'({next_pt.tag, next_pt.z, next_pt.y, next_pt.x});
        s_axis_tlast <= next_pt.last;
        s_axis_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                    : $urandom_range(0, 20);
          idle_left  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, once, early in the random part
  always @(negedge clk_i) begin
    if (rst_ni && !hold_done && points_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: ready pattern switches between a few modes
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(50, 400);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (cycle_count[2:0] != 3'd0);
        endcase
      end
    end
  end

  // Monitor: check result beats first, then fold in the accepted point beat
  always @(posedge clk_i) begin
    cell_result_t got, want;
    point_t       p;
    cycle_count++;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.tag      = m_axis_tdata[TAG_W-1:0];
        got.dsq      = m_axis_tdata[TAG_W +: DSQ_W];
        got.root_len = m_axis_tdata[TAG_W+DSQ_W +: DIST_W];
        got.spill    = m_axis_tuser;
        if (diameter_q.size() == 0) begin
          report_mismatch($sformatf("result beat tag %h with no cell pending", got.tag));
        end else begin
          want = diameter_q.pop_front();
          results_checked++;
          if (want.spill) spill_results++;
          if (got.tag !== want.tag)
            report_mismatch($sformatf("result_tag %h, expected %h", got.tag, want.tag));
          if (got.dsq !== want.dsq)
            report_mismatch($sformatf("tag %h max_dist_sq %0d, expected %0d",
                                      want.tag, got.dsq, want.dsq));
          if (got.root_len !== want.root_len)
            report_mismatch($sformatf("tag %h max_dist %0d, expected %0d",
                                      want.tag, got.root_len, want.root_len));
          if (got.spill !== want.spill)
            report_mismatch($sformatf("tag %h point_overflow %b, expected %b",
                                      want.tag, got.spill, want.spill));
        end
      end
      in_beat_done <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        p.x    = s_axis_tdata[0 +: COORD_W];
        p.y    = s_axis_tdata[COORD_W +: COORD_W];
        p.z    = s_axis_tdata[2*COORD_W +: COORD_W];
        p.tag  = s_axis_tdata[3*COORD_W +: TAG_W];
        p.last = s_axis_tlast;
        fold_point(p);
        points_accepted++;
      end
      // input back-pressure, for the summary
      if (s_axis_tvalid && !s_axis_tready) begin
        stall_run++;
        if (stall_run > stall_longest) stall_longest = stall_run;
      end else begin
        stall_run = 0;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (cycle_count >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned sz, pick;

    // Directed cells: single points, extremes, coincident points, tag changes
    queue_point(COORD_MIN, COORD_MAX, coord_t'(0), 16'hFFFF, 1'b1);
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 16'h0000, 1'b0);
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 16'hA5C3, 1'b1);
    queue_point(coord_t'(5), coord_t'(-7), coord_t'(9), 16'h0001, 1'b0);
    queue_point(coord_t'(5), coord_t'(-7), coord_t'(9), 16'h0001, 1'b1);
    queue_point(coord_t'(0), coord_t'(0), coord_t'(0), 16'h0100, 1'b0);
    queue_point(coord_t'(1), coord_t'(1), coord_t'(1), 16'h0100, 1'b0);
    queue_point(coord_t'(0), coord_t'(0), coord_t'(-2), 16'h0101, 1'b1);
    queue_point(COORD_MAX, coord_t'(0), coord_t'(0), 16'h5A5A, 1'b0);
    queue_point(coord_t'(0), coord_t'(0), coord_t'(0), 16'h5A5A, 1'b0);
    queue_point(COORD_MIN, coord_t'(0), coord_t'(0), 16'h5A5A, 1'b1);
    queue_point(coord_t'(0), COORD_MIN, coord_t'(0), 16'h00FF, 1'b0);
    queue_point(coord_t'(0), COORD_MAX, coord_t'(0), 16'h00FF, 1'b1);
    queue_point(coord_t'(0), coord_t'(0), COORD_MAX, 16'hFF00, 1'b0);
    queue_point(coord_t'(0), coord_t'(0), COORD_MIN, 16'hFF00, 1'b1);
    queue_point(coord_t'(-1), coord_t'(-1), coord_t'(-1), 16'h7FFF, 1'b1);
    queue_point(coord_t'(0), coord_t'(0), coord_t'(0), 16'h8000, 1'b1);

    // Random cells, mostly short, a few long
    while (points_total < 17 + RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      sz = $urandom_range(1, 3);
      else if (pick < 80) sz = $urandom_range(4, 12);
      else if (pick < 96) sz = $urandom_range(13, 40);
      else                sz = $urandom_range(41, 120);
      queue_cell(sz);
    end

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    while (points_accepted < points_total) @(negedge clk_i);
    while (diameter_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("%0d points in %0d checked cells, %0d of them flagged past capacity",
             points_accepted, results_checked, spill_results);
    $display("longest input back-pressure %0d cycles, %0d cycles run, %0d mismatches",
             stall_longest, cycle_count, err_count);
    if (err_count == 0 && diameter_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== point_set_max_pairwise_distance_core.f =====
rtl/core/psmpd_pkg.sv
rtl/core/psmpd_point_mem.sv
rtl/core/psmpd_dist_pipe.sv
rtl/core/psmpd_isqrt.sv
rtl/core/point_set_max_pairwise_distance_core.sv
verif/testbench.sv
